// File: hdl/emft_pkg.sv
// Shared types and constants for the exact-match forwarding table.
// Holds the request/response words, the token that walks the cell chain and the codes.
// No dependencies.
package emft_pkg;

	// Number of entries, one per cell in the chain (range 1 to 256)
	localparam int TABLE_SIZE = 16;

	localparam int ADDR_W  = 16;
	localparam int NBR_W   = 8;
	localparam int DELAY_W = 16;
	localparam int STAT_W  = 3;

	// Request types
	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
	localparam logic [STAT_W-1:0] ST_HIT      = 3'd3;
	localparam logic [STAT_W-1:0] ST_DEFAULT  = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOROUTE  = 3'd5;

	// Configuration register indexes (byte address = 4 * index)
	localparam int REG_IDX_W = 2;
	localparam int PADDR_W   = 4;
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_VALID    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_NEIGHBOR = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_DELAY    = 2'd2;

	// Input word
	typedef struct packed {
		logic               req_type;
		logic [ADDR_W-1:0]  address;
		logic [NBR_W-1:0]   neighbor;
		logic [DELAY_W-1:0] delay;
	} req_t;

	// Output word
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [NBR_W-1:0]   next_neighbor;
		logic [DELAY_W-1:0] next_delay;
	} rsp_t;

	// Default route settings
	typedef struct packed {
		logic               valid;
		logic [NBR_W-1:0]   neighbor;
		logic [DELAY_W-1:0] delay;
	} dflt_t;

	// Request token passed from cell to cell.
	// neighbor/delay carry the new entry, replaced by the matched entry's data on a hit.
	typedef struct packed {
		logic               valid;
		logic               req_type;
		logic [ADDR_W-1:0]  address;
		logic [NBR_W-1:0]   neighbor;
		logic [DELAY_W-1:0] delay;
		logic               found;
		logic               free_seen;
		logic               inserted;
	} tok_t;

endpackage

// File: hdl/emft_cell.sv
// One table cell: holds a single entry and forwards the request token to the next cell.
// Compares the token address, takes an insert into the first free cell, registers the token.
// Depends on emft_pkg.
module emft_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hold,
	input  emft_pkg::tok_t tok_in,
	output emft_pkg::tok_t tok_out
);
	import emft_pkg::*;

	logic               ent_valid_q;
	logic [ADDR_W-1:0]  ent_addr_q;
	logic [NBR_W-1:0]   ent_nbr_q;
	logic [DELAY_W-1:0] ent_delay_q;
	tok_t               tok_q;
	tok_t               tok_nxt;
	logic               match;
	logic               take;

	// Compare and slot selection
	assign match = ent_valid_q && (ent_addr_q == tok_in.address) && !tok_in.found;
	assign take  = tok_in.valid && (tok_in.req_type == REQ_ADD) && !ent_valid_q &&
		!tok_in.found && !tok_in.inserted;

	always_comb begin
		tok_nxt           = tok_in;
		tok_nxt.found     = tok_in.found | match;
		tok_nxt.free_seen = tok_in.free_seen | !ent_valid_q;
		tok_nxt.inserted  = tok_in.inserted | take;
		if (match) begin
			tok_nxt.neighbor = ent_nbr_q;
			tok_nxt.delay    = ent_delay_q;
		end
	end

	// Entry occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
		end else if (take) begin
			ent_valid_q <= 1'b1;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (take) begin
			ent_addr_q  <= tok_in.address;
			ent_nbr_q   <= tok_in.neighbor;
			ent_delay_q <= tok_in.delay;
		end
	end

	// Token stage; holds only when the downstream side cannot take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (!(tok_q.valid && hold)) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: hdl/emft_regs.sv
// APB-style register file for the default route settings.
// Decodes write and read accesses, presents the settings as one struct.
// Depends on emft_pkg.
module emft_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [emft_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output emft_pkg::dflt_t               dflt
);
	import emft_pkg::*;

	dflt_t                dflt_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[PADDR_W-1:2];

	// Register writes; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEFAULT_VALID:    dflt_q.valid    <= pwdata[0];
				REG_DEFAULT_NEIGHBOR: dflt_q.neighbor <= pwdata[NBR_W-1:0];
				REG_DEFAULT_DELAY:    dflt_q.delay    <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_DEFAULT_VALID:    prdata = {31'd0, dflt_q.valid};
			REG_DEFAULT_NEIGHBOR: prdata = {{(32-NBR_W){1'b0}}, dflt_q.neighbor};
			REG_DEFAULT_DELAY:    prdata = {{(32-DELAY_W){1'b0}}, dflt_q.delay};
			default:              prdata = '0;
		endcase
	end

	assign dflt = dflt_q;

endmodule

// File: hdl/exact_match_forwarding_table_top.sv
// Exact-match forwarding table, top level: cell chain, result register, register file.
// The request token is registered in every cell of the chain in turn, the last cell feeding the result
// stage, which registers the response word.
// A single token walks the chain: a new request is stalled until that token leaves the last cell.
// Reset: asynchronous, active low; empties the table and clears the default route.
module exact_match_forwarding_table_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  emft_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output emft_pkg::rsp_t               rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [emft_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import emft_pkg::*;

	tok_t                  tok [TABLE_SIZE+1];
	tok_t                  tok_head;
	logic [TABLE_SIZE-1:0] tok_valid_vec;
	dflt_t                 dflt;
	logic                  busy_q;
	logic                  accept;
	logic                  out_hold;
	logic                  tok_exit;
	tok_t                  last;
	rsp_t                  rsp_nxt;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	emft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dflt    (dflt)
	);

	// Input side: one request in the chain at a time
	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;

	always_comb begin
		tok_head           = '0;
		tok_head.valid     = accept;
		tok_head.req_type  = req.req_type;
		tok_head.address   = req.address;
		tok_head.neighbor  = req.neighbor;
		tok_head.delay     = req.delay;
	end

	assign tok[0] = tok_head;

	// Cell chain
	for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
		emft_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.hold    ((i == TABLE_SIZE - 1) && out_hold),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
		assign tok_valid_vec[i] = tok[i+1].valid;
	end

	assign last     = tok[TABLE_SIZE];
	assign out_hold = rsp_valid_q && rsp_stall;
	assign tok_exit = last.valid && !out_hold;

	// Result decode at the end of the chain
	always_comb begin
		rsp_nxt = '0;
		if (last.req_type == REQ_ADD) begin
			if (last.inserted) begin
				rsp_nxt.status = ST_INSERTED;
			end else if (!last.free_seen) begin
				rsp_nxt.status = ST_FULL;
			end else begin
				rsp_nxt.status = ST_DUP;
			end
		end else if (last.found) begin
			rsp_nxt.status        = ST_HIT;
			rsp_nxt.next_neighbor = last.neighbor;
			rsp_nxt.next_delay    = last.delay;
		end else if (dflt.valid) begin
			rsp_nxt.status        = ST_DEFAULT;
			rsp_nxt.next_neighbor = dflt.neighbor;
			rsp_nxt.next_delay    = dflt.delay;
		end else begin
			rsp_nxt.status = ST_NOROUTE;
		end
	end

	// Busy flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tok_exit) begin
				busy_q <= 1'b0;
			end
			if (tok_exit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (tok_exit) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// Never more than one token in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_valid_vec) <= 1)
		else $error("more than one token in the cell chain");

	// An idle block has an empty chain
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok_valid_vec == '0))
		else $error("token in chain while not busy");

	// A new result only follows a token leaving the last cell
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(last.valid))
		else $error("result without a token at the chain end");
`endif

endmodule
